/* sv/lru_key_list_macros.svh */
// Assertion macros for the checker file of the key list.
// Needs only a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef LRU_KEY_LIST_MACROS_SVH
`define LRU_KEY_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("key list assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LKL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key list assertion failed");

`endif

/* sv/lkl_pkg.sv */
// Package for the recency-ordered key list: sizes, command codes, helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lkl_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int KEY_BITS   = 32;
    localparam int PORT_BITS  = 32;
    localparam int OCC_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_TOUCH  = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;

    typedef logic [KEY_BITS-1:0] t_tag;

    // Control that every cell of the chain sees in the cycle of a word.
    typedef struct packed {
        logic insert;
        logic touch;
    } t_cell_ctl;

    // Port word to stored tag: truncate or zero-extend to KEY_BITS.
    function automatic t_tag to_tag(input logic [PORT_BITS-1:0] word);
        t_tag tag;
        for (int b = 0; b < KEY_BITS; b++) begin
            tag[b] = (b < PORT_BITS) ? word[b] : 1'b0;
        end
        return tag;
    endfunction

    // Stored tag to port word: low bits, zero-extended when the tag is narrower.
    function automatic logic [PORT_BITS-1:0] to_word(input t_tag tag);
        logic [PORT_BITS-1:0] word;
        for (int b = 0; b < PORT_BITS; b++) begin
            word[b] = (b < KEY_BITS) ? tag[b] : 1'b0;
        end
        return word;
    endfunction

endpackage

/* sv/lkl_cell.sv */
// One slot of the key list chain: holds a tag, compares it, shifts from its neighbor.
// Depends on lkl_pkg.
`timescale 1ns / 1ps

module lkl_cell (
    input  logic              i_clk,
    input  lkl_pkg::t_cell_ctl i_ctl,
    input  lkl_pkg::t_tag     i_tag,
    input  logic              i_valid,
    input  logic              i_prior,
    input  logic              i_hit,
    input  lkl_pkg::t_tag     i_prev_key,
    output lkl_pkg::t_tag     o_key,
    output logic              o_prior
);

    lkl_pkg::t_tag r_key;
    logic          match;
    logic          shift;

    assign match   = i_valid && (r_key == i_tag);
    assign o_prior = i_prior || match;

    // On a touch hit only the cells up to the first match move back one place.
    assign shift = i_ctl.insert || (i_ctl.touch && i_hit && !i_prior);

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_key <= i_prev_key;
        end
    end

    assign o_key = r_key;

endmodule

/* sv/lru_key_list.sv */
// Top level of the recency-ordered key list: cell chain, occupancy and result register.
// Depends on lkl_pkg and lkl_cell.
//
//   channel | handshake                | payload
//   --------+--------------------------+----------------------------------------
//   input   | start / busy             | i_command, i_key
//   result  | o_valid (one-cycle mark) | o_hit, o_evicted_valid, o_evicted_key
//
// A word is taken at every edge with start high; busy never rises, so one word a cycle.
// Its result shows in the next cycle for exactly one cycle, from the output register.
// The cost of a cycle is the compare in every cell plus the first-match ripple down the chain.
// Reset empties the list by clearing the occupancy count; the slots are not cleared.
// The receiver cannot stall, so nothing holds a result back.
`timescale 1ns / 1ps

module lru_key_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_key,
    output logic        o_valid,
    output logic        o_hit,
    output logic        o_evicted_valid,
    output logic [31:0] o_evicted_key
);

    localparam int N = lkl_pkg::LIST_DEPTH;

    logic [lkl_pkg::OCC_W-1:0] r_occ, n_occ;
    logic                      r_valid;
    logic                      r_hit, n_hit;
    logic                      r_ev_valid, n_ev_valid;
    logic [31:0]               r_ev_key, n_ev_key;

    lkl_pkg::t_tag      tag;
    lkl_pkg::t_cell_ctl ctl;
    lkl_pkg::t_tag      keys  [N];
    lkl_pkg::t_tag      prevk [N];
    logic [N:0]         prior;
    logic               found;
    logic               full;

    assign tag      = lkl_pkg::to_tag(i_key);
    assign full     = (r_occ == lkl_pkg::OCC_W'(N));
    assign prior[0] = 1'b0;
    assign found    = prior[N];

    assign ctl.insert = start && (i_command == lkl_pkg::CMD_INSERT);
    assign ctl.touch  = start && (i_command == lkl_pkg::CMD_TOUCH);

    for (genvar i = 0; i < N; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign prevk[i] = tag;
        end else begin : g_body
            assign prevk[i] = keys[i-1];
        end
        lkl_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_tag      (tag),
            .i_valid    (lkl_pkg::OCC_W'(i) < r_occ),
            .i_prior    (prior[i]),
            .i_hit      (found),
            .i_prev_key (prevk[i]),
            .o_key      (keys[i]),
            .o_prior    (prior[i+1])
        );
    end

    always_comb begin
        n_occ      = r_occ;
        n_hit      = 1'b0;
        n_ev_valid = 1'b0;
        n_ev_key   = '0;
        unique case (i_command) inside
            lkl_pkg::CMD_LOOKUP, lkl_pkg::CMD_TOUCH: begin
                n_hit = found;
            end
            lkl_pkg::CMD_INSERT: begin
                if (full) begin
                    n_ev_valid = 1'b1;
                    n_ev_key   = lkl_pkg::to_word(keys[N-1]);
                end else if (start) begin
                    n_occ = r_occ + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_occ   <= n_occ;
            r_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_hit      <= n_hit;
            r_ev_valid <= n_ev_valid;
            r_ev_key   <= n_ev_key;
        end
    end

    assign busy            = 1'b0;
    assign o_valid         = r_valid;
    assign o_hit           = r_hit;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_key   = r_ev_key;

endmodule

/* sv/lkl_checker.sv */
// Port-level checker for the key list, attached to the top level by bind.
// Depends on lru_key_list_macros.svh and lkl_pkg.
`timescale 1ns / 1ps
`include "lru_key_list_macros.svh"

module lkl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_command,
    input logic        o_valid,
    input logic        o_hit,
    input logic        o_evicted_valid,
    input logic [31:0] o_evicted_key
);

    logic insert_taken;

    assign insert_taken = start && !busy && (i_command == lkl_pkg::CMD_INSERT);

    // Every accepted word gives its result in the next cycle, and nothing else does.
    `LKL_ASSERT_NEXT(a_result_follows, start && !busy, o_valid)
    `LKL_ASSERT_NEXT(a_no_stray_result, !(start && !busy), !o_valid)

    // An insert never reports a hit, and the evicted key is zero whenever no eviction is reported.
    `LKL_ASSERT_NEXT(a_insert_no_hit, insert_taken, !o_hit)
    `LKL_ASSERT_NOW(a_evict_key_zero, o_valid && !o_evicted_valid, o_evicted_key == 32'd0)

endmodule

bind lru_key_list lkl_checker u_lkl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_command       (i_command),
    .o_valid         (o_valid),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid),
    .o_evicted_key   (o_evicted_key)
);
